>>> rtl/rro_pkg.sv
`timescale 1ns / 1ps

package rro_pkg;

	typedef logic [2:0] reg_idx_t;

	localparam reg_idx_t REG_RECT_LEFT   = 3'd0;
	localparam reg_idx_t REG_RECT_TOP    = 3'd1;
	localparam reg_idx_t REG_RECT_WIDTH  = 3'd2;
	localparam reg_idx_t REG_RECT_HEIGHT = 3'd3;
	localparam reg_idx_t REG_DRAW_MODE   = 3'd4;
	localparam reg_idx_t REG_PERCENT     = 3'd5;
	localparam reg_idx_t REG_FILL_COLOR  = 3'd6;

	typedef logic [2:0] mode_t;

	localparam mode_t MODE_PASS      = 3'd0;
	localparam mode_t MODE_FILL      = 3'd1;
	localparam mode_t MODE_DARKEN    = 3'd2;
	localparam mode_t MODE_LIGHTEN   = 3'd3;
	localparam mode_t MODE_INVERT    = 3'd4;
	localparam mode_t MODE_INV_LIGHT = 3'd5;

	typedef enum logic [2:0] {
		OP_PASS,
		OP_FILL,
		OP_DARK,
		OP_LIGHT,
		OP_INV
	} op_t;

	localparam logic [6:0]  PCT_MAX       = 7'd100;
	localparam logic [7:0]  CH_MAX        = 8'd255;
	// mean of three channels above 127 <=> channel sum >= 3 * 128
	localparam logic [9:0]  MEAN_SUM_THR  = 10'd384;
	// x / 100 == (x * 5243) >> 19 for x < 43690
	localparam logic [12:0] RECIP_100     = 13'd5243;
	localparam int          RECIP_SHIFT   = 19;

endpackage

>>> rtl/rgb565_rect_overlay.sv
`timescale 1ns / 1ps

// Throughput: one pixel per cycle; three register stages, each holds only while the next is full.
// The per-channel multiply and the divide-by-100 reciprocal multiply sit in separate stages.
// Reset (arst_n low, asynchronous): counters to 0, pipeline empty, registers to
// their reset values (percent 100, all others 0).
module rgb565_rect_overlay
	import rro_pkg::*;
#(
	parameter int FRAME_WIDTH  = 160,
	parameter int FRAME_HEIGHT = 120
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] pixel_in
	input  logic        s_axis_tuser,   // [0] frame_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] pixel_out
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	localparam int CW = (FRAME_WIDTH  > 1) ? $clog2(FRAME_WIDTH)  : 1;
	localparam int RW = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
	localparam logic [10:0] FW = 11'(FRAME_WIDTH);
	localparam logic [10:0] FH = 11'(FRAME_HEIGHT);
	localparam logic [CW-1:0] COL_LAST = CW'(FRAME_WIDTH - 1);
	localparam logic [RW-1:0] ROW_LAST = RW'(FRAME_HEIGHT - 1);

	function automatic logic in_span(input logic [10:0] pos, input logic [10:0] start,
			input logic [10:0] len, input logic [10:0] limit);
		logic [10:0] stop;
		stop = start + len;
		if (stop > limit)
			stop = limit;
		return (start < limit) && (pos >= start) && (pos < stop);
	endfunction

	// configuration
	logic [7:0]  rect_left_q;
	logic [6:0]  rect_top_q;
	logic [7:0]  rect_width_q;
	logic [6:0]  rect_height_q;
	mode_t       draw_mode_q;
	logic [6:0]  percent_q;
	logic [15:0] fill_q;   // kept byte-swapped

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_left_q   <= '0;
			rect_top_q    <= '0;
			rect_width_q  <= '0;
			rect_height_q <= '0;
			draw_mode_q   <= MODE_PASS;
			percent_q     <= PCT_MAX;
			fill_q        <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RECT_LEFT:   rect_left_q   <= cfg_wdata[7:0];
				REG_RECT_TOP:    rect_top_q    <= cfg_wdata[6:0];
				REG_RECT_WIDTH:  rect_width_q  <= cfg_wdata[7:0];
				REG_RECT_HEIGHT: rect_height_q <= cfg_wdata[6:0];
				REG_DRAW_MODE:   draw_mode_q   <= cfg_wdata[2:0];
				REG_PERCENT:     percent_q     <= cfg_wdata[6:0];
				REG_FILL_COLOR:  fill_q        <= {cfg_wdata[7:0], cfg_wdata[15:8]};
				default: ;
			endcase
		end
	end

	// pipeline flow control
	logic v1_q, v2_q, vo_q;
	logic rdy1, rdy2, rdy_o, accept;

	assign rdy_o         = !vo_q || m_axis_tready;
	assign rdy2          = !v2_q || rdy_o;
	assign rdy1          = !v1_q || rdy2;
	assign s_axis_tready = rdy1;
	assign accept        = s_axis_tvalid && rdy1;
	assign m_axis_tvalid = vo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (rdy1)
				v1_q <= s_axis_tvalid;
			if (rdy2)
				v2_q <= v1_q;
			if (rdy_o)
				vo_q <= v2_q;
		end
	end

	// position counters
	logic [CW-1:0] col_q, col_pos;
	logic [RW-1:0] row_q, row_pos;
	logic          hit;

	assign col_pos = s_axis_tuser ? '0 : col_q;
	assign row_pos = s_axis_tuser ? '0 : row_q;
	assign hit = in_span(11'(col_pos), {3'b0, rect_left_q}, {3'b0, rect_width_q}, FW) &&
		in_span(11'(row_pos), {4'b0, rect_top_q}, {4'b0, rect_height_q}, FH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_pos == COL_LAST) begin
				col_q <= '0;
				row_q <= (row_pos == ROW_LAST) ? '0 : row_pos + 1'b1;
			end else begin
				col_q <= col_pos + 1'b1;
				row_q <= row_pos;
			end
		end
	end

	// stage 1: input register
	logic [15:0] px_s1;
	logic        hit_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			px_s1  <= s_axis_tdata;
			hit_s1 <= hit;
		end
	end

	// stage 1 -> 2: unpack, pick operation, channel products
	logic [15:0] plain;
	logic [7:0]  ch [3];
	logic [9:0]  ch_sum;
	logic [6:0]  pct;
	logic [6:0]  factor;
	op_t         op;
	logic [7:0]  mul_a [3];
	logic [14:0] prod [3];

	always_comb begin
		plain  = {px_s1[7:0], px_s1[15:8]};
		ch[0]  = {plain[15:11], 3'b000};
		ch[1]  = {plain[10:5], 2'b00};
		ch[2]  = {plain[4:0], 3'b000};
		ch_sum = 10'(ch[0]) + 10'(ch[1]) + 10'(ch[2]);
		pct    = (percent_q > PCT_MAX) ? PCT_MAX : percent_q;
		op     = OP_PASS;
		if (hit_s1) begin
			case (draw_mode_q)
				MODE_FILL:      op = OP_FILL;
				MODE_DARKEN:    op = OP_DARK;
				MODE_LIGHTEN:   op = OP_LIGHT;
				MODE_INVERT:    op = OP_INV;
				MODE_INV_LIGHT: op = (ch_sum >= MEAN_SUM_THR) ? OP_DARK : OP_LIGHT;
				default:        op = OP_PASS;
			endcase
		end
		factor = (op == OP_DARK) ? (PCT_MAX - pct) : pct;
		for (int i = 0; i < 3; i++) begin
			mul_a[i] = (op == OP_DARK) ? ch[i] : (CH_MAX - ch[i]);
			prod[i]  = 15'(mul_a[i] * factor);
		end
	end

	logic [15:0] px_s2;
	op_t         op_s2;
	logic [7:0]  ch_s2   [3];
	logic [14:0] prod_s2 [3];

	always_ff @(posedge clk) begin
		if (rdy2) begin
			px_s2 <= px_s1;
			op_s2 <= op;
			for (int i = 0; i < 3; i++) begin
				ch_s2[i]   <= ch[i];
				prod_s2[i] <= prod[i];
			end
		end
	end

	// stage 2 -> output: divide by 100, combine, repack
	logic [27:0] scaled [3];
	logic [7:0]  quo    [3];
	logic [8:0]  lsum   [3];
	logic [7:0]  res    [3];
	logic [15:0] packed_px;
	logic [15:0] result;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			scaled[i] = 28'(prod_s2[i] * RECIP_100);
			quo[i]    = scaled[i][RECIP_SHIFT +: 8];
			lsum[i]   = 9'(ch_s2[i]) + 9'(quo[i]);
			case (op_s2)
				OP_DARK:  res[i] = quo[i];
				OP_LIGHT: res[i] = lsum[i][8] ? CH_MAX : lsum[i][7:0];
				default:  res[i] = ~ch_s2[i];
			endcase
		end
		packed_px = {res[0][7:3], res[1][7:2], res[2][7:3]};
		case (op_s2)
			OP_PASS: result = px_s2;
			OP_FILL: result = fill_q;
			default: result = {packed_px[7:0], packed_px[15:8]};
		endcase
	end

	logic [15:0] out_q;

	always_ff @(posedge clk) begin
		if (rdy_o)
			out_q <= result;
	end

	assign m_axis_tdata = out_q;

endmodule
